[rtl/c1dg_pkg.sv]
package c1dg_pkg;

  localparam int MaxChannelsDef = 64;
  localparam int MaxLengthDef   = 256;
  localparam int AccW           = 48;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 9;

  localparam logic [1:0] StrideRst    = 2'd1;
  localparam logic       DepthwiseRst = 1'b0;
  localparam logic       GeluRst      = 1'b1;
  localparam logic [6:0] InChRst      = 7'd64;
  localparam logic [6:0] OutChRst     = 7'd64;
  localparam logic [8:0] InLenRst     = 9'd256;

  typedef enum logic [1:0] {
    ACT_WEIGHT  = 2'd0,
    ACT_BIAS    = 2'd1,
    ACT_SAMPLE  = 2'd2,
    ACT_COMPUTE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRIDE    = 3'd0,
    CFG_DEPTHWISE = 3'd1,
    CFG_GELU      = 3'd2,
    CFG_IN_CH     = 3'd3,
    CFG_OUT_CH    = 3'd4,
    CFG_IN_LEN    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    action_e            action;
    logic [13:0]        address;
    logic signed [15:0] value;
    logic [5:0]         out_channel;
    logic [7:0]         out_time;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    status_e            status;
  } out_item_t;

  function automatic logic [9:0] gelu_tail(input logic [5:0] idx);
    logic [9:0] v;
    unique case (idx)
      6'd0:  v = 10'd0;
      6'd1:  v = 10'd231;
      6'd2:  v = 10'd411;
      6'd3:  v = 10'd543;
      6'd4:  v = 10'd632;
      6'd5:  v = 10'd681;
      6'd6:  v = 10'd696;
      6'd7:  v = 10'd684;
      6'd8:  v = 10'd650;
      6'd9:  v = 10'd600;
      6'd10: v = 10'd541;
      6'd11: v = 10'd476;
      6'd12: v = 10'd410;
      6'd13: v = 10'd347;
      6'd14: v = 10'd287;
      6'd15: v = 10'd233;
      6'd16: v = 10'd186;
      6'd17: v = 10'd146;
      6'd18: v = 10'd113;
      6'd19: v = 10'd85;
      6'd20: v = 10'd64;
      6'd21: v = 10'd47;
      6'd22: v = 10'd34;
      6'd23: v = 10'd24;
      6'd24: v = 10'd17;
      6'd25: v = 10'd11;
      6'd26: v = 10'd8;
      6'd27: v = 10'd5;
      6'd28: v = 10'd3;
      6'd29: v = 10'd2;
      6'd30: v = 10'd1;
      6'd31: v = 10'd1;
      6'd32: v = 10'd1;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/c1dg_ram.sv]
module c1dg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/conv1d_k3_gelu_engine.sv]
// Channel    Direction  Handshake                  Payload
// item       in         start / busy               item_i (in_item_t)
// result     out        result_valid_o (strobe)    result_o (out_item_t)
// config     in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Load beats raise no busy. A compute beat holds busy through check, base, three
// taps for each of N input channels (N = input channels summed, 1 in depthwise
// mode), drain, round and the GELU steps if on; out of range it skips to the result.
// The one shared multiplier handles one tap per cycle, fed by the weight and sample
// memories. Reset clears control state and sets the config registers; the memories
// are not cleared. The result strobe lasts one cycle and cannot be stalled.
module conv1d_k3_gelu_engine
  import c1dg_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDef,
  parameter int MAX_LENGTH   = MaxLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_item_t            item_i,
  output logic                result_valid_o,
  output out_item_t           result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int W_DEPTH = MAX_CHANNELS * MAX_CHANNELS * 3;
  localparam int S_DEPTH = MAX_CHANNELS * MAX_LENGTH;
  localparam int B_DEPTH = MAX_CHANNELS;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int SA_W    = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
  localparam int BA_W    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int LN_W    = $clog2(MAX_LENGTH + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'h001,
    S_CHECK  = 11'h002,
    S_BASE   = 11'h004,
    S_MAC    = 11'h008,
    S_DRAIN1 = 11'h010,
    S_DRAIN2 = 11'h020,
    S_ROUND  = 11'h040,
    S_GELU1  = 11'h080,
    S_GELU2  = 11'h100,
    S_GELU3  = 11'h200,
    S_DONE   = 11'h400
  } state_e;

  state_e state_q, state_d;

  logic [1:0] stride_q;
  logic       dw_q;
  logic       gelu_q;
  logic [6:0] in_ch_q;
  logic [6:0] out_ch_q;
  logic [8:0] in_len_q;

  logic [5:0]            oc_q;
  logic [7:0]            ot_q;
  logic [WA_W-1:0]       w_addr_q;
  logic [SA_W-1:0]       s_base_q;
  logic [1:0]            k_q;
  logic [CH_W-1:0]       c_q;
  logic                  v1_q, v2_q;
  logic signed [31:0]    prod_q;
  logic [19:0]           gsum_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [15:0]    res_q;
  status_e               status_q;

  logic accept;
  logic [CH_W-1:0] ic_c, ocn_c, nc_c, nch_m1;
  logic [LN_W-1:0] len_c, ol_c;
  logic st2, range_bad;
  logic [8:0] ot_st;
  logic signed [10:0] src;
  logic tap_ok, last_tap;
  logic [SA_W-1:0] s_raddr;
  logic [15:0] w_rdata, s_rdata, b_rdata;

  logic signed [AccW-1:0]  acc_rnd;
  logic signed [AccW-16:0] q_full;
  logic sat_hi, sat_lo;

  logic [16:0] xe, u;
  logic [4:0]  gj;
  logic [8:0]  gf;
  logic        gbig;
  logic [9:0]  tail_a, tail_b;
  logic [20:0] msum;
  logic [11:0] gm;

  logic signed [15:0] mul_a, mul_b;
  logic prod_en;

  assign busy           = (state_q != S_IDLE);
  assign accept         = start && !busy;
  assign result_valid_o = (state_q == S_DONE);
  assign result_o.result_value = res_q;
  assign result_o.status       = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= StrideRst;
      dw_q     <= DepthwiseRst;
      gelu_q   <= GeluRst;
      in_ch_q  <= InChRst;
      out_ch_q <= OutChRst;
      in_len_q <= InLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STRIDE:    stride_q <= cfg_wdata_i[1:0];
        CFG_DEPTHWISE: dw_q     <= cfg_wdata_i[0];
        CFG_GELU:      gelu_q   <= cfg_wdata_i[0];
        CFG_IN_CH:     in_ch_q  <= cfg_wdata_i[6:0];
        CFG_OUT_CH:    out_ch_q <= cfg_wdata_i[6:0];
        CFG_IN_LEN:    in_len_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (in_ch_q == '0) begin
      ic_c = CH_W'(1);
    end else if (32'(in_ch_q) > 32'(MAX_CHANNELS)) begin
      ic_c = CH_W'(MAX_CHANNELS);
    end else begin
      ic_c = CH_W'(in_ch_q);
    end
    if (out_ch_q == '0) begin
      ocn_c = CH_W'(1);
    end else if (32'(out_ch_q) > 32'(MAX_CHANNELS)) begin
      ocn_c = CH_W'(MAX_CHANNELS);
    end else begin
      ocn_c = CH_W'(out_ch_q);
    end
    if (in_len_q == '0) begin
      len_c = LN_W'(1);
    end else if (32'(in_len_q) > 32'(MAX_LENGTH)) begin
      len_c = LN_W'(MAX_LENGTH);
    end else begin
      len_c = LN_W'(in_len_q);
    end
    nc_c      = dw_q ? ic_c : ocn_c;
    nch_m1    = dw_q ? '0 : ic_c - CH_W'(1);
    st2       = (stride_q == 2'd2);
    ol_c      = st2 ? ((len_c - LN_W'(1)) >> 1) + LN_W'(1) : len_c;
    range_bad = (32'(oc_q) >= 32'(nc_c)) || (32'(ot_q) >= 32'(ol_c));
  end

  always_comb begin
    ot_st    = st2 ? {ot_q, 1'b0} : {1'b0, ot_q};
    src      = $signed({2'b00, ot_st}) + $signed({9'd0, k_q}) - 11'sd1;
    tap_ok   = !src[10] && (32'(src[9:0]) < 32'(len_c));
    s_raddr  = s_base_q + SA_W'(src[9:0]);
    last_tap = (k_q == 2'd2) && (c_q == nch_m1);
  end

  c1dg_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (accept && item_i.action == ACT_WEIGHT &&
              32'(item_i.address) < 32'(W_DEPTH)),
    .waddr_i (WA_W'(item_i.address)),
    .wdata_i (item_i.value),
    .raddr_i (w_addr_q),
    .rdata_o (w_rdata)
  );

  c1dg_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (accept && item_i.action == ACT_BIAS &&
              32'(item_i.address) < 32'(B_DEPTH)),
    .waddr_i (BA_W'(item_i.address)),
    .wdata_i (item_i.value),
    .raddr_i (BA_W'(oc_q)),
    .rdata_o (b_rdata)
  );

  c1dg_ram #(.WIDTH(16), .DEPTH(S_DEPTH)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (accept && item_i.action == ACT_SAMPLE &&
              32'(item_i.address) < 32'(S_DEPTH)),
    .waddr_i (SA_W'(item_i.address)),
    .wdata_i (item_i.value),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_comb begin
    acc_rnd = acc_q + 48'sd16384;
    q_full  = acc_rnd[AccW-1:15];
    sat_hi  = q_full > 33'sd32767;
    sat_lo  = q_full < -33'sd32768;
  end

  always_comb begin
    xe     = {res_q[15], res_q};
    u      = res_q[15] ? (17'd0 - xe) : xe;
    gj     = u[13:9];
    gf     = u[8:0];
    gbig   = |u[16:14];
    tail_a = gelu_tail({1'b0, gj});
    tail_b = gelu_tail({1'b0, gj} + 6'd1);
    msum   = {1'b0, gsum_q} + {1'b0, prod_q[19:0]} + 21'd256;
    gm     = gbig ? '0 : msum[20:9];
  end

  always_comb begin
    prod_en = v1_q || state_q == S_CHECK || state_q == S_GELU1 || state_q == S_GELU2;
    priority if (v1_q) begin
      mul_a = w_rdata;
      mul_b = s_rdata;
    end else if (state_q == S_CHECK) begin
      mul_a = 16'(oc_q);
      mul_b = dw_q ? 16'(MAX_LENGTH) : 16'(ic_c);
    end else if (state_q == S_GELU1) begin
      mul_a = 16'(tail_a);
      mul_b = 16'(10'd512 - {1'b0, gf});
    end else begin
      mul_a = 16'(tail_b);
      mul_b = 16'(gf);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && item_i.action == ACT_COMPUTE) state_d = S_CHECK;
      end
      S_CHECK:  state_d = range_bad ? S_DONE : S_BASE;
      S_BASE:   state_d = S_MAC;
      S_MAC: begin
        if (last_tap) state_d = S_DRAIN1;
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_ROUND;
      S_ROUND:  state_d = gelu_q ? S_GELU1 : S_DONE;
      S_GELU1:  state_d = S_GELU2;
      S_GELU2:  state_d = S_GELU3;
      S_GELU3:  state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == S_MAC) && tap_ok;
      v2_q    <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      oc_q <= item_i.out_channel;
      ot_q <= item_i.out_time;
    end
    if (prod_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == S_GELU2) begin
      gsum_q <= prod_q[19:0];
    end
    if (state_q == S_BASE) begin
      acc_q <= AccW'($signed(b_rdata)) <<< 12;
    end else if (v2_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    unique case (state_q)
      S_CHECK: begin
        res_q    <= '0;
        status_q <= ST_RANGE;
      end
      S_BASE: begin
        k_q <= '0;
        c_q <= '0;
        if (dw_q) begin
          w_addr_q <= WA_W'({2'b00, oc_q} + {1'b0, oc_q, 1'b0});
          s_base_q <= SA_W'(prod_q);
        end else begin
          w_addr_q <= WA_W'(prod_q + (prod_q <<< 1));
          s_base_q <= '0;
        end
      end
      S_MAC: begin
        w_addr_q <= w_addr_q + WA_W'(1);
        if (k_q == 2'd2) begin
          k_q      <= '0;
          c_q      <= c_q + CH_W'(1);
          s_base_q <= s_base_q + SA_W'(MAX_LENGTH);
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
      S_ROUND: begin
        if (sat_hi) begin
          res_q    <= 16'sh7FFF;
          status_q <= ST_SAT;
        end else if (sat_lo) begin
          res_q    <= 16'sh8000;
          status_q <= ST_SAT;
        end else begin
          res_q    <= q_full[15:0];
          status_q <= ST_OK;
        end
      end
      S_GELU3: begin
        res_q <= res_q[15] ? (16'd0 - {4'd0, gm}) : (res_q - {4'd0, gm});
      end
      default: begin
      end
    endcase
  end

  a_compute_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.action == ACT_COMPUTE |=> busy)
    else $error("compute beat did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.action != ACT_COMPUTE |=> !busy && !result_valid_o)
    else $error("load beat started work or gave a result");

  a_strobe_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy && !result_valid_o)
    else $error("result strobe not followed by idle");

  a_acc_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == S_MAC || state_q == S_DRAIN1 || state_q == S_DRAIN2))
    else $error("product accumulated outside the tap walk");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == ST_RANGE |-> result_o.result_value == '0)
    else $error("out-of-range result is not zero");

endmodule
